/* hdl/scfa_pkg.sv */
// ----------------------------------------------------------------------------
// scfa_pkg: shared definitions of the size class free list allocator
// Arena and class geometry, result codes, the header store request bundle
// and small address helpers.
// ----------------------------------------------------------------------------
package scfa_pkg;

  localparam int ARENA_BYTES   = 65536;
  localparam int ADDR_SPAN     = 65536;
  localparam int CLASS_COUNT   = 3;
  localparam int CLASS_BYTES   = 128;
  localparam int HEADER_BYTES  = 16;
  localparam int GRANULE_BYTES = 8;
  localparam int HDR_DEPTH     = 8192;

  localparam int ADDR_W      = 16;
  localparam int OFF_W       = 17;
  localparam int SUM_W       = OFF_W + 1;
  localparam int HDR_AW      = $clog2(HDR_DEPTH);
  localparam int HDR_W       = 2 * ADDR_W;
  localparam int CLASS_SHIFT = $clog2(CLASS_BYTES);
  localparam int GRAN_SHIFT  = 3;
  localparam int CLS_W       = ADDR_W - CLASS_SHIFT;
  localparam int CLS_IDX_W   = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

  localparam int EFF_LIMIT_I = (ARENA_BYTES < ADDR_SPAN) ? ARENA_BYTES : ADDR_SPAN;
  localparam logic [OFF_W-1:0] EFF_LIMIT   = OFF_W'(EFF_LIMIT_I);
  localparam logic [OFF_W-1:0] LIMIT_RESET = OFF_W'(40960);

  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;
  localparam logic REG_ARENA_LIMIT = 1'b0;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_FREED     = 3'd3,
    ST_IGNORED   = 3'd4
  } status_t;

  typedef struct packed {
    logic              rd_en;
    logic [HDR_AW-1:0] rd_addr;
    logic              wr_en;
    logic [HDR_AW-1:0] wr_addr;
    logic [HDR_W-1:0]  wr_data;
  } hdr_req_t;

  function automatic logic [HDR_AW-1:0] hdr_idx(input logic [ADDR_W-1:0] payload);
    logic [ADDR_W-1:0] base;
    base = payload - ADDR_W'(HEADER_BYTES);
    return base[GRAN_SHIFT +: HDR_AW];
  endfunction

  function automatic logic [OFF_W-1:0] round_granule(input logic [OFF_W-1:0] bytes);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(bytes) + SUM_W'(GRANULE_BYTES - 1);
    sum = sum & ~SUM_W'(GRANULE_BYTES - 1);
    return sum[OFF_W-1:0];
  endfunction

  function automatic logic [OFF_W-1:0] class_reserve(input logic [CLS_IDX_W-1:0] cls);
    logic [OFF_W-1:0] span;
    span = (OFF_W'(cls) + OFF_W'(1)) * OFF_W'(CLASS_BYTES);
    return round_granule(span);
  endfunction

endpackage

/* hdl/scfa_hdr_ram.sv */
// ----------------------------------------------------------------------------
// scfa_hdr_ram: chunk header store
// One entry per header granule, one read and one write port, registered
// read data. Entries hold the chunk size and the free list link.
// ----------------------------------------------------------------------------
module scfa_hdr_ram (
  input  logic                     clk,
  input  scfa_pkg::hdr_req_t       req,
  output logic [scfa_pkg::HDR_W-1:0] rd_data
);
  import scfa_pkg::*;

  logic [HDR_W-1:0] hdr_mem [HDR_DEPTH];
  logic [HDR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      hdr_mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= hdr_mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/size_class_free_list_allocator_unit.sv */
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_unit: segregated free list allocator
// Allocates and frees byte ranges of an arena, with one free list per size
// class and a bump pointer for fresh and large chunks.
// ----------------------------------------------------------------------------
// When a beat is accepted, the chunk header it needs is read from the
// header store, and the registered header comes back in the next cycle.
// When the beat completes, the lists, bump pointer and header are updated
// and the result is loaded into the output register. A new input beat is
// accepted only once the previous beat has completed; a stalled result
// holds completion of the following beat. The header store has no clearing
// pass and is usable right after reset.
module size_class_free_list_allocator_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: request_size [15:0], block_address [31:16]
  input  logic [31:0]                   in_tdata,
  // in_tuser: operation [0]
  input  logic                          in_tuser,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // out_tdata: payload_address [15:0]
  output logic [15:0]                   out_tdata,
  // out_tuser: status [2:0]
  output logic [2:0]                    out_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [scfa_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [scfa_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [scfa_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import scfa_pkg::*;

  logic [OFF_W-1:0]  limit_r;
  logic [OFF_W-1:0]  limit_nxt;
  logic [ADDR_W-1:0] heads_r   [CLASS_COUNT];
  logic [ADDR_W-1:0] heads_nxt [CLASS_COUNT];
  logic [OFF_W-1:0]  bump_r;
  logic [OFF_W-1:0]  bump_nxt;

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic              s1_op_r;
  logic [ADDR_W-1:0] s1_size_r;
  logic [ADDR_W-1:0] s1_addr_r;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r;
  logic [ADDR_W-1:0] out_addr_nxt;
  status_t           out_status_r;
  status_t           out_status_nxt;

  hdr_req_t          hdr_req;
  logic [HDR_W-1:0]  hdr_rd_data;

  logic              in_op;
  logic [ADDR_W-1:0] in_size;
  logic [ADDR_W-1:0] in_addr;
  logic              accept;
  logic              complete;
  logic              cfg_write;
  logic [CLS_W-1:0]  in_cls;
  logic [ADDR_W-1:0] rd_payload;

  logic [CLS_W-1:0]     cls;
  logic                 cls_small;
  logic [CLS_IDX_W-1:0] cls_i;
  logic [ADDR_W-1:0]    head;
  logic [OFF_W-1:0]     reserve;
  logic [SUM_W-1:0]     chunk_end;
  logic [OFF_W-1:0]     limit_eff;
  logic [ADDR_W-1:0]    bump_payload;
  logic [ADDR_W-1:0]    hsize;
  logic [CLS_W-1:0]     hcls;
  logic [CLS_IDX_W-1:0] hcls_i;
  logic                 hdr_ok;

  assign in_op   = in_tuser;
  assign in_size = in_tdata[15:0];
  assign in_addr = in_tdata[31:16];

  assign in_tready = !s1_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign complete  = s1_valid_r && (!out_valid_r || out_tready);

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_ARENA_LIMIT);
  assign limit_nxt  = cfg_write ? cfg_pwdata[OFF_W-1:0] : limit_r;

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_ARENA_LIMIT) begin
      cfg_prdata = CFG_DW'(limit_r);
    end
  end

  // Header read issued with the accepted beat.
  always_comb begin
    in_cls     = in_size[ADDR_W-1:CLASS_SHIFT];
    rd_payload = in_addr;
    if (in_op == OP_ALLOC) begin
      rd_payload = '0;
      for (int k = 0; k < CLASS_COUNT; k++) begin
        if (in_cls == CLS_W'(k)) begin
          rd_payload = heads_r[k];
        end
      end
    end
  end

  // Completion of the beat held in stage one.
  always_comb begin
    cls          = s1_size_r[ADDR_W-1:CLASS_SHIFT];
    cls_small    = cls < CLS_W'(CLASS_COUNT);
    cls_i        = cls[CLS_IDX_W-1:0];
    head         = '0;
    hsize        = hdr_rd_data[ADDR_W-1:0];
    hcls         = hsize[ADDR_W-1:CLASS_SHIFT];
    hcls_i       = hcls[CLS_IDX_W-1:0];
    hdr_ok       = (hsize != '0) && (hcls < CLS_W'(CLASS_COUNT));
    limit_eff    = (limit_r > EFF_LIMIT) ? EFF_LIMIT : limit_r;
    reserve      = cls_small ? class_reserve(cls_i) : round_granule(OFF_W'(s1_size_r));
    chunk_end    = SUM_W'(bump_r) + SUM_W'(HEADER_BYTES) + SUM_W'(reserve);
    bump_payload = bump_r[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);

    for (int k = 0; k < CLASS_COUNT; k++) begin
      if (cls_small && (cls_i == CLS_IDX_W'(k))) begin
        head = heads_r[k];
      end
    end

    for (int k = 0; k < CLASS_COUNT; k++) begin
      heads_nxt[k] = heads_r[k];
    end
    bump_nxt        = bump_r;
    out_valid_nxt   = out_tready ? 1'b0 : out_valid_r;
    out_addr_nxt    = out_addr_r;
    out_status_nxt  = out_status_r;
    hdr_req.rd_en   = accept;
    hdr_req.rd_addr = hdr_idx(rd_payload);
    hdr_req.wr_en   = 1'b0;
    hdr_req.wr_addr = '0;
    hdr_req.wr_data = '0;

    if (complete) begin
      out_valid_nxt = 1'b1;
      out_addr_nxt  = '0;
      if (s1_op_r == OP_ALLOC) begin
        if (s1_size_r == '0) begin
          out_status_nxt = ST_ZERO_SIZE;
        end else if (cls_small && (head != '0)) begin
          for (int k = 0; k < CLASS_COUNT; k++) begin
            if (cls_i == CLS_IDX_W'(k)) begin
              heads_nxt[k] = hdr_rd_data[HDR_W-1:ADDR_W];
            end
          end
          out_addr_nxt   = head;
          out_status_nxt = ST_ALLOCATED;
        end else if (chunk_end > SUM_W'(limit_eff)) begin
          out_status_nxt = ST_NO_SPACE;
        end else begin
          hdr_req.wr_en   = 1'b1;
          hdr_req.wr_addr = hdr_idx(bump_payload);
          hdr_req.wr_data = HDR_W'(s1_size_r);
          bump_nxt        = chunk_end[OFF_W-1:0];
          out_addr_nxt    = bump_payload;
          out_status_nxt  = ST_ALLOCATED;
        end
      end else begin
        out_status_nxt = ST_IGNORED;
        if ((s1_addr_r >= ADDR_W'(HEADER_BYTES)) && hdr_ok) begin
          hdr_req.wr_en   = 1'b1;
          hdr_req.wr_addr = hdr_idx(s1_addr_r);
          for (int k = 0; k < CLASS_COUNT; k++) begin
            if (hcls_i == CLS_IDX_W'(k)) begin
              hdr_req.wr_data = {heads_r[k], hsize};
              heads_nxt[k]    = s1_addr_r;
            end
          end
          out_status_nxt = ST_FREED;
        end
      end
    end
  end

  assign s1_valid_nxt = accept ? 1'b1 : (complete ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      bump_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < CLASS_COUNT; k++) begin
        heads_r[k] <= '0;
      end
    end else begin
      limit_r     <= limit_nxt;
      bump_r      <= bump_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      for (int k = 0; k < CLASS_COUNT; k++) begin
        heads_r[k] <= heads_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r   <= in_op;
      s1_size_r <= in_size;
      s1_addr_r <= in_addr;
    end
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  scfa_hdr_ram u_hdr_ram (
    .clk     (clk),
    .req     (hdr_req),
    .rd_data (hdr_rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_status_r;

  // The bump pointer never runs past the addressable arena.
  a_bump_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bump_r <= EFF_LIMIT)
    else $error("bump pointer beyond arena");

  // The header store never sees a read and a write in the same cycle.
  a_no_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
    !(hdr_req.rd_en && hdr_req.wr_en))
    else $error("header read and write collide");

  // A header write only happens while a beat completes.
  a_wr_on_complete: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_req.wr_en |-> (s1_valid_r && complete))
    else $error("header write outside completion");

  // A new result only appears after a beat sat in stage one.
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && !out_tready)) |-> $past(s1_valid_r))
    else $error("result without a pending beat");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the size class free list allocator unit
// Drives allocate and free beats into the stream input and checks every
// result beat against a local model of the class lists, bump pointer and
// chunk headers, or against the listed result for typed directed beats. A
// short table of directed beats comes first, then random phases under several
// arena limits, with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb;
  import scfa_pkg::*;

  localparam int CLK_HALF_NS    = 6;
  localparam int RESET_CYCLES   = 7;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int TIMEOUT_NS     = 2_400_000;
  localparam int FREED_KEEP     = 32;
  localparam logic [CFG_AW-1:0] ADDR_ARENA_LIMIT = CFG_AW'(4 * int'(REG_ARENA_LIMIT));

  typedef struct packed {
    logic [15:0] payload;
    status_t     status;
  } alloc_result_t;

  typedef struct {
    logic        op;
    logic [15:0] size;
    logic [15:0] addr;
    bit          typed;
    logic [15:0] exp_payload;
    status_t     exp_status;
  } directed_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic        cfg_pready;

  size_class_free_list_allocator_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Local copy of the allocator state.
  logic [15:0] list_head [CLASS_COUNT];
  logic [16:0] bump_ptr;
  logic [16:0] arena_limit_q;
  logic [31:0] hdr_mem [HDR_DEPTH];
  bit          hdr_valid [HDR_DEPTH];

  alloc_result_t pending_results [$];
  logic [15:0]   live_chunks [$];
  logic [15:0]   freed_chunks [$];
  logic [12:0]   hdr_slots_used [$];

  int error_count = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_gap = 0;
  bit rx_hold_req = 1'b0;

  directed_row_t directed_rows [25] = '{
    '{OP_ALLOC, 16'd0,     16'hFFFF, 1'b1, 16'd0,    ST_ZERO_SIZE},
    '{OP_FREE,  16'hFFFF,  16'd0,    1'b1, 16'd0,    ST_IGNORED},
    '{OP_FREE,  16'd0,     16'd15,   1'b1, 16'd0,    ST_IGNORED},
    '{OP_ALLOC, 16'd1,     16'd0,    1'b1, 16'd16,   ST_ALLOCATED},
    '{OP_ALLOC, 16'd127,   16'd0,    1'b0, 16'd0,    ST_ALLOCATED},
    '{OP_ALLOC, 16'd128,   16'd0,    1'b0, 16'd0,    ST_ALLOCATED},
    '{OP_ALLOC, 16'd383,   16'd0,    1'b0, 16'd0,    ST_ALLOCATED},
    '{OP_ALLOC, 16'd384,   16'd0,    1'b0, 16'd0,    ST_ALLOCATED},
    '{OP_ALLOC, 16'd385,   16'd0,    1'b0, 16'd0,    ST_ALLOCATED},
    '{OP_FREE,  16'd0,     16'd16,   1'b0, 16'd0,    ST_ALLOCATED},
    '{OP_FREE,  16'd0,     16'd160,  1'b0, 16'd0,    ST_ALLOCATED},
    '{OP_ALLOC, 16'd64,    16'd0,    1'b0, 16'd0,    ST_ALLOCATED},
    '{OP_ALLOC, 16'd100,   16'd0,    1'b0, 16'd0,    ST_ALLOCATED},
    '{OP_ALLOC, 16'd5,     16'd0,    1'b0, 16'd0,    ST_ALLOCATED},
    '{OP_FREE,  16'd0,     16'd976,  1'b1, 16'd0,    ST_IGNORED},
    '{OP_FREE,  16'd0,     16'd1376, 1'b1, 16'd0,    ST_IGNORED},
    '{OP_FREE,  16'd0,     16'd576,  1'b0, 16'd0,    ST_ALLOCATED},
    '{OP_ALLOC, 16'd300,   16'd0,    1'b0, 16'd0,    ST_ALLOCATED},
    '{OP_ALLOC, 16'd256,   16'd0,    1'b0, 16'd0,    ST_ALLOCATED},
    '{OP_FREE,  16'd0,     16'd307,  1'b0, 16'd0,    ST_ALLOCATED},
    '{OP_ALLOC, 16'd200,   16'd0,    1'b0, 16'd0,    ST_ALLOCATED},
    '{OP_ALLOC, 16'd65535, 16'd0,    1'b1, 16'd0,    ST_NO_SPACE},
    '{OP_ALLOC, 16'd38584, 16'd0,    1'b1, 16'd2328, ST_ALLOCATED},
    '{OP_ALLOC, 16'd1,     16'd0,    1'b1, 16'd0,    ST_NO_SPACE},
    '{OP_FREE,  16'd0,     16'd2328, 1'b1, 16'd0,    ST_IGNORED}
  };

  initial begin
    clk = 1'b0;
    forever #CLK_HALF_NS clk = ~clk;
  end

  initial begin
    #TIMEOUT_NS;
    $display("size_class_free_list_allocator_unit test failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [12:0] header_slot(input logic [15:0] payload);
    logic [15:0] base;
    base = payload - 16'(HEADER_BYTES);
    return base[15:3];
  endfunction

  function automatic int unsigned granule_up(input int unsigned n);
    return (n + GRANULE_BYTES - 1) / GRANULE_BYTES * GRANULE_BYTES;
  endfunction

  // Applies one request to the local state and returns the answer it gets.
  task automatic serve_request(input logic op, input logic [15:0] size,
                               input logic [15:0] addr, output alloc_result_t res);
    int unsigned cls;
    int unsigned reserve;
    int unsigned stop;
    int unsigned lim;
    logic [12:0] idx;
    logic [15:0] hsize;
    res.payload = 16'd0;
    if (op == OP_ALLOC) begin
      cls = size / CLASS_BYTES;
      if (size == 16'd0) begin
        res.status = ST_ZERO_SIZE;
      end else if (cls < CLASS_COUNT && list_head[cls] != 16'd0) begin
        res.payload = list_head[cls];
        list_head[cls] = hdr_mem[header_slot(res.payload)][31:16];
        res.status = ST_ALLOCATED;
      end else begin
        if (cls < CLASS_COUNT) reserve = granule_up((cls + 1) * CLASS_BYTES);
        else reserve = granule_up(size);
        stop = int'(bump_ptr) + HEADER_BYTES + reserve;
        lim = arena_limit_q;
        if (lim > ARENA_BYTES) lim = ARENA_BYTES;
        if (lim > ADDR_SPAN) lim = ADDR_SPAN;
        if (stop > lim) begin
          res.status = ST_NO_SPACE;
        end else begin
          res.payload = 16'(int'(bump_ptr) + HEADER_BYTES);
          idx = header_slot(res.payload);
          hdr_mem[idx] = {16'd0, size};
          if (!hdr_valid[idx]) hdr_slots_used.push_back(idx);
          hdr_valid[idx] = 1'b1;
          bump_ptr = 17'(stop);
          res.status = ST_ALLOCATED;
        end
      end
      if (res.status == ST_ALLOCATED) live_chunks.push_back(res.payload);
    end else begin
      if (addr < 16'(HEADER_BYTES)) begin
        res.status = ST_IGNORED;
      end else begin
        idx = header_slot(addr);
        hsize = hdr_mem[idx][15:0];
        cls = hsize / CLASS_BYTES;
        if (hsize == 16'd0 || cls >= CLASS_COUNT) begin
          res.status = ST_IGNORED;
        end else begin
          hdr_mem[idx] = {list_head[cls], hsize};
          list_head[cls] = addr;
          res.status = ST_FREED;
          freed_chunks.push_back(addr);
          if (freed_chunks.size() > FREED_KEEP) void'(freed_chunks.pop_front());
        end
      end
    end
  endtask

  task automatic send_beat(input logic op, input logic [15:0] size, input logic [15:0] addr,
                           input bit typed, input logic [15:0] t_payload,
                           input status_t t_status);
    int gap;
    alloc_result_t res;
    gap = tx_idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {addr, size};
    in_tuser <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    serve_request(op, size, addr, res);
    if (typed) begin
      res.payload = t_payload;
      res.status = t_status;
    end
    pending_results.push_back(res);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_access(input bit wr, input logic [16:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= ADDR_ARENA_LIMIT;
    cfg_pwdata <= CFG_DW'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (wr) begin
      arena_limit_q = value;
    end else if (cfg_prdata !== CFG_DW'(arena_limit_q)) begin
      report_mismatch($sformatf("arena_limit read %0d, expected %0d",
                                cfg_prdata, arena_limit_q));
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Mostly allocations and frees of chunks handed out earlier, with some noise.
  // Foreign and double frees corrupt the lists, so they only come when wild is set.
  task automatic next_random_request(input bit wild, output logic op,
                                     output logic [15:0] size, output logic [15:0] addr);
    int pick;
    int k;
    logic [15:0] edge_sizes [6];
    edge_sizes = '{16'd1, 16'd127, 16'd128, 16'd255, 16'd256, 16'd383};
    pick = $urandom_range(0, 99);
    op = OP_ALLOC;
    size = 16'($urandom_range(1, 383));
    addr = 16'($urandom);
    if (pick < 4) begin
      size = 16'd0;
    end else if (pick < 8) begin
      if ($urandom_range(0, 7) == 0) size = 16'($urandom_range(384, 65535));
      else size = 16'($urandom_range(384, 1536));
    end else if (pick < 52) begin
      if ($urandom_range(0, 4) == 0) size = edge_sizes[$urandom_range(0, 5)];
    end else if (pick < 56) begin
      op = OP_FREE;
      size = 16'($urandom);
      addr = 16'($urandom_range(0, HEADER_BYTES - 1));
    end else if (wild && pick < 62 && hdr_slots_used.size() != 0) begin
      op = OP_FREE;
      size = 16'($urandom);
      k = $urandom_range(0, hdr_slots_used.size() - 1);
      addr = 16'(HEADER_BYTES + int'(hdr_slots_used[k]) * 8 + $urandom_range(0, 7));
    end else if (wild && pick < 66 && freed_chunks.size() != 0) begin
      op = OP_FREE;
      size = 16'($urandom);
      addr = freed_chunks[$urandom_range(0, freed_chunks.size() - 1)];
    end else if (live_chunks.size() != 0) begin
      op = OP_FREE;
      size = 16'($urandom);
      k = $urandom_range(0, live_chunks.size() - 1);
      addr = live_chunks[k];
      live_chunks.delete(k);
    end
  endtask

  task automatic run_random_phase(input int count, input bit wild);
    logic op;
    logic [15:0] size;
    logic [15:0] addr;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
      end
      next_random_request(wild, op, size, addr);
      send_beat(op, size, addr, 1'b0, 16'd0, ST_ALLOCATED);
    end
    drain_results();
  endtask

  always @(posedge clk) begin : result_check
    alloc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat addr %0d status %0d",
                                  out_tdata, out_tuser));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.payload)
          report_mismatch($sformatf("payload_address %0d, expected %0d",
                                    out_tdata, want.payload));
        if (out_tuser !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d (%s)",
                                    out_tuser, want.status, want.status.name()));
      end
      rx_gap = rx_idle_on ? $urandom_range(0, 6) : 0;
    end
  end

  initial begin : receiver
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end
      if (rx_gap > 0) begin
        out_tready <= 1'b0;
        rx_gap--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    for (int c = 0; c < CLASS_COUNT; c++) list_head[c] = 16'd0;
    for (int h = 0; h < HDR_DEPTH; h++) begin
      hdr_mem[h] = 32'd0;
      hdr_valid[h] = 1'b0;
    end
    bump_ptr = 17'd0;
    arena_limit_q = LIMIT_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cfg_access(1'b0, 17'd0);
    foreach (directed_rows[i])
      send_beat(directed_rows[i].op, directed_rows[i].size, directed_rows[i].addr,
                directed_rows[i].typed, directed_rows[i].exp_payload,
                directed_rows[i].exp_status);
    drain_results();
    live_chunks.delete();
    freed_chunks.delete();

    cfg_access(1'b1, 17'd0);
    cfg_access(1'b0, 17'd0);
    run_random_phase(40, 1'b0);

    cfg_access(1'b1, 17'd65536);
    cfg_access(1'b0, 17'd0);
    rx_hold_req = 1'b1;
    run_random_phase(500, 1'b0);

    cfg_access(1'b1, 17'd65535);
    run_random_phase(150, 1'b0);

    cfg_access(1'b1, 17'($urandom_range(0, 65536)));
    cfg_access(1'b0, 17'd0);
    run_random_phase(200, 1'b0);

    cfg_access(1'b1, 17'd65536);
    run_random_phase(260, 1'b1);

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("size_class_free_list_allocator_unit test passed");
    end else begin
      $display("size_class_free_list_allocator_unit test failed");
    end
    $finish;
  end

endmodule
